FILE: hdl/two_axis_encoder_seek_controller_defines.svh
// Assertion macros for the seek controller.
`ifndef TWO_AXIS_ENCODER_SEEK_CONTROLLER_DEFINES_SVH
`define TWO_AXIS_ENCODER_SEEK_CONTROLLER_DEFINES_SVH

// checked only out of reset
`define TASC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every rising clock edge, reset included
`define TASC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: hdl/tasc_pkg.sv
package tasc_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int POS_WIDTH   = 16;
   localparam int BAND_WIDTH  = 15;
   localparam int DUTY_WIDTH  = 8;
   localparam int WORD_WIDTH  = 16;
   localparam int CSR_IDX_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH = 15;

   localparam logic [2:0] MODE_TICK     = 3'd0;
   localparam logic [2:0] MODE_LOAD_AZ  = 3'd1;
   localparam logic [2:0] MODE_LOAD_EL  = 3'd2;
   localparam logic [2:0] MODE_ORIGIN   = 3'd3;
   localparam logic [2:0] MODE_SEEK     = 3'd4;
   localparam logic [2:0] MODE_HOME     = 3'd5;
   localparam logic [2:0] MODE_DRIVE_AZ = 3'd6;
   localparam logic [2:0] MODE_DRIVE_EL = 3'd7;

   localparam logic [1:0] ACT_IDLE    = 2'd0;
   localparam logic [1:0] ACT_SEEK    = 2'd1;
   localparam logic [1:0] ACT_HOME_AZ = 2'd2;
   localparam logic [1:0] ACT_HOME_EL = 2'd3;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_FAR_BAND   = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_NEAR_BAND  = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_FULL_POWER = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MID_POWER  = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_LOW_POWER  = 3'd4;

   localparam logic [BAND_WIDTH-1:0] FAR_BAND_RST   = 15'd80;
   localparam logic [BAND_WIDTH-1:0] NEAR_BAND_RST  = 15'd40;
   localparam logic [DUTY_WIDTH-1:0] FULL_POWER_RST = 8'd255;
   localparam logic [DUTY_WIDTH-1:0] MID_POWER_RST  = 8'd192;
   localparam logic [DUTY_WIDTH-1:0] LOW_POWER_RST  = 8'd127;

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_SEEK    = 4'b0010,
      ST_HOME_AZ = 4'b0100,
      ST_HOME_EL = 4'b1000
   } state_type;

   typedef struct packed {
      logic [2:0]            mode;
      logic [WORD_WIDTH-1:0] target_word;
      logic                  drive_dir;
      logic [DUTY_WIDTH-1:0] drive_power;
      logic                  az_edge;
      logic                  az_level;
      logic                  el_edge;
      logic                  el_level;
      logic                  az_index;
      logic                  el_index;
   } req_type;

   typedef struct packed {
      logic signed [POS_WIDTH-1:0] az_position;
      logic signed [POS_WIDTH-1:0] el_position;
      logic                        az_direction;
      logic [DUTY_WIDTH-1:0]       az_duty;
      logic                        el_direction;
      logic [DUTY_WIDTH-1:0]       el_duty;
      logic [1:0]                  activity;
      logic                        finished;
   } rsp_type;

   function automatic logic [COUNT_WIDTH-1:0] step_count(
      input logic [COUNT_WIDTH-1:0] c,
      input logic                   edge_seen,
      input logic                   level
   );
      logic [COUNT_WIDTH-1:0] r;
      r = c;
      if (edge_seen) begin
         r = level ? c + COUNT_WIDTH'(1) : c - COUNT_WIDTH'(1);
      end
      return r;
   endfunction

   // sign-magnitude target to a wrapped counter value
   function automatic logic [COUNT_WIDTH-1:0] goal_to_count(
      input logic [WORD_WIDTH-1:0] word
   );
      logic [COUNT_WIDTH-1:0] m;
      m = COUNT_WIDTH'(word[WORD_WIDTH-2:0]);
      if (word[WORD_WIDTH-1]) begin
         m = -m;
      end
      return m;
   endfunction

endpackage

FILE: hdl/two_axis_encoder_seek_controller.sv
// Two-axis encoder seek controller.
// req_ channel: one transaction per clock tick carries a command (mode, target
//   word, manual drive) plus the encoder edge/level samples and index switches.
// rsp_ channel: one transaction per request with both positions, the motor
//   drive registers, the activity code and a completion flag.
// csr_ channel: register writes (index, data); always ready. Registers must be
//   written only while no request is in flight; the block does not enforce it.
// A transaction passes through the request register, then the whole update
//   (count, command, one seek or homing step) into the response register.
// One transaction per cycle unless stalled; the state update is a single pass.
// A stalled response holds; the request register still takes one more
//   transaction behind it, and req_stall rises only when both are full.
// Commands arriving while seeking or homing are dropped.
// Reset (synchronous) clears both counts, the targets, the drive registers,
//   returns to idle, restores the register defaults and empties the pipeline.
`include "two_axis_encoder_seek_controller_defines.svh"

module two_axis_encoder_seek_controller (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  tasc_pkg::req_type                      req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output tasc_pkg::rsp_type                      rsp_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [tasc_pkg::CSR_IDX_WIDTH-1:0]     csr_index,
   input  logic [tasc_pkg::CSR_DATA_WIDTH-1:0]    csr_data
);

   localparam int CW = tasc_pkg::COUNT_WIDTH;
   localparam int DW = tasc_pkg::DUTY_WIDTH;
   localparam int BW = tasc_pkg::BAND_WIDTH;
   localparam int WW = tasc_pkg::WORD_WIDTH;

   logic [BW-1:0] far_band_ff, near_band_ff;
   logic [DW-1:0] full_power_ff, mid_power_ff, low_power_ff;

   logic              in_valid_ff;
   tasc_pkg::req_type in_ff;
   logic              out_valid_ff;
   tasc_pkg::rsp_type out_ff, out_in;
   logic              advance;

   logic [CW-1:0]       az_count_ff, az_count_in, el_count_ff, el_count_in;
   logic [WW-1:0]       az_goal_ff, az_goal_in, el_goal_ff, el_goal_in;
   tasc_pkg::state_type state_ff, state_in;
   logic                az_dir_ff, az_dir_in, el_dir_ff, el_dir_in;
   logic [DW-1:0]       az_duty_ff, az_duty_in, el_duty_ff, el_duty_in;
   logic                done;
   logic [CW-1:0]       az_aim, el_aim;
   logic [DW-1:0]       tier;
   logic [1:0]          act_code;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         far_band_ff   <= tasc_pkg::FAR_BAND_RST;
         near_band_ff  <= tasc_pkg::NEAR_BAND_RST;
         full_power_ff <= tasc_pkg::FULL_POWER_RST;
         mid_power_ff  <= tasc_pkg::MID_POWER_RST;
         low_power_ff  <= tasc_pkg::LOW_POWER_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            tasc_pkg::CSR_FAR_BAND:   far_band_ff   <= csr_data[BW-1:0];
            tasc_pkg::CSR_NEAR_BAND:  near_band_ff  <= csr_data[BW-1:0];
            tasc_pkg::CSR_FULL_POWER: full_power_ff <= csr_data[DW-1:0];
            tasc_pkg::CSR_MID_POWER:  mid_power_ff  <= csr_data[DW-1:0];
            tasc_pkg::CSR_LOW_POWER:  low_power_ff  <= csr_data[DW-1:0];
            default: ;
         endcase
      end
   end

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_ff <= req_data;
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         az_count_ff <= '0;
         el_count_ff <= '0;
         az_goal_ff  <= '0;
         el_goal_ff  <= '0;
         state_ff    <= tasc_pkg::ST_IDLE;
         az_dir_ff   <= 1'b0;
         el_dir_ff   <= 1'b0;
         az_duty_ff  <= '0;
         el_duty_ff  <= '0;
      end else if (advance) begin
         az_count_ff <= az_count_in;
         el_count_ff <= el_count_in;
         az_goal_ff  <= az_goal_in;
         el_goal_ff  <= el_goal_in;
         state_ff    <= state_in;
         az_dir_ff   <= az_dir_in;
         el_dir_ff   <= el_dir_in;
         az_duty_ff  <= az_duty_in;
         el_duty_ff  <= el_duty_in;
      end
   end

   always_comb begin
      az_count_in = tasc_pkg::step_count(az_count_ff, in_ff.az_edge, in_ff.az_level);
      el_count_in = tasc_pkg::step_count(el_count_ff, in_ff.el_edge, in_ff.el_level);
      az_goal_in  = az_goal_ff;
      el_goal_in  = el_goal_ff;
      state_in    = state_ff;
      az_dir_in   = az_dir_ff;
      el_dir_in   = el_dir_ff;
      az_duty_in  = az_duty_ff;
      el_duty_in  = el_duty_ff;
      done        = 1'b0;

      if (state_ff == tasc_pkg::ST_IDLE) begin
         unique case (in_ff.mode)
            tasc_pkg::MODE_LOAD_AZ: az_goal_in = in_ff.target_word;
            tasc_pkg::MODE_LOAD_EL: el_goal_in = in_ff.target_word;
            tasc_pkg::MODE_ORIGIN: begin
               az_count_in = tasc_pkg::goal_to_count(az_goal_ff);
               el_count_in = tasc_pkg::goal_to_count(el_goal_ff);
            end
            tasc_pkg::MODE_SEEK: state_in = tasc_pkg::ST_SEEK;
            tasc_pkg::MODE_HOME: state_in = tasc_pkg::ST_HOME_AZ;
            tasc_pkg::MODE_DRIVE_AZ: begin
               az_dir_in  = in_ff.drive_dir;
               az_duty_in = in_ff.drive_power;
            end
            tasc_pkg::MODE_DRIVE_EL: begin
               el_dir_in  = in_ff.drive_dir;
               el_duty_in = in_ff.drive_power;
            end
            default: ;
         endcase
      end

      az_aim = tasc_pkg::goal_to_count(az_goal_in);
      el_aim = tasc_pkg::goal_to_count(el_goal_in);
      if (el_goal_in[WW-2:0] <= near_band_ff) begin
         tier = low_power_ff;
      end else if (el_goal_in[WW-2:0] <= far_band_ff) begin
         tier = mid_power_ff;
      end else begin
         tier = full_power_ff;
      end

      if (state_in == tasc_pkg::ST_SEEK) begin
         az_dir_in  = $signed(az_count_in) < $signed(az_aim);
         az_duty_in = (az_count_in == az_aim) ? '0 : full_power_ff;
         el_dir_in  = $signed(el_count_in) < $signed(el_aim);
         el_duty_in = (el_count_in == el_aim) ? '0 : tier;
         if (az_count_in == az_aim && el_count_in == el_aim) begin
            state_in = tasc_pkg::ST_IDLE;
            done     = 1'b1;
         end
      end else begin
         if (state_in == tasc_pkg::ST_HOME_AZ) begin
            az_dir_in = 1'b0;
            if (in_ff.az_index) begin
               az_duty_in  = '0;
               az_count_in = '0;
               state_in    = tasc_pkg::ST_HOME_EL;
            end else begin
               az_duty_in = full_power_ff;
            end
         end
         if (state_in == tasc_pkg::ST_HOME_EL) begin
            if (in_ff.el_index) begin
               el_dir_in   = 1'b0;
               el_duty_in  = '0;
               el_count_in = '0;
               state_in    = tasc_pkg::ST_IDLE;
               done        = 1'b1;
            end else begin
               el_dir_in  = 1'b1;
               el_duty_in = full_power_ff;
            end
         end
      end

      unique case (state_in)
         tasc_pkg::ST_SEEK:    act_code = tasc_pkg::ACT_SEEK;
         tasc_pkg::ST_HOME_AZ: act_code = tasc_pkg::ACT_HOME_AZ;
         tasc_pkg::ST_HOME_EL: act_code = tasc_pkg::ACT_HOME_EL;
         default:              act_code = tasc_pkg::ACT_IDLE;
      endcase

      out_in.az_position  = tasc_pkg::POS_WIDTH'(signed'(az_count_in));
      out_in.el_position  = tasc_pkg::POS_WIDTH'(signed'(el_count_in));
      out_in.az_direction = az_dir_in;
      out_in.az_duty      = az_duty_in;
      out_in.el_direction = el_dir_in;
      out_in.el_duty      = el_duty_in;
      out_in.activity     = act_code;
      out_in.finished     = done;
   end

   `TASC_ASSERT_ALWAYS(a_reset_idle, $past(reset) |-> (state_ff == tasc_pkg::ST_IDLE && !out_valid_ff), "state or response not cleared by reset")
   `TASC_ASSERT(a_finish_idle, (out_valid_ff && out_ff.finished) |-> (out_ff.activity == tasc_pkg::ACT_IDLE), "finished while still active")
   `TASC_ASSERT(a_advance_fills, advance |=> out_valid_ff, "advanced transaction lost")
   `TASC_ASSERT(a_stall_cause, req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall), "request stalled without a full pipeline")
   `TASC_ASSERT(a_home_stop, (advance && out_in.finished && state_ff == tasc_pkg::ST_HOME_EL) |-> (out_in.el_position == '0 && out_in.el_duty == '0), "homing finished without zeroing elevation")

endmodule

FILE: verif/two_axis_encoder_seek_controller_tb.sv
module two_axis_encoder_seek_controller_tb;

   localparam int PHASE_ITEMS   = 200;
   localparam int PHASE_COUNT   = 8;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int DRAIN_TAIL    = 8;
   localparam int SEEK_REACH    = 120;
   localparam int CSR_INDEX_TOP = (1 << tasc_pkg::CSR_IDX_WIDTH) - 1;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct {
      tasc_pkg::req_type req;
      bit                typed;
      tasc_pkg::rsp_type rsp;
   } stim_row_type;

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                req_valid;
   logic                                req_stall;
   tasc_pkg::req_type                   req_data;
   logic                                rsp_valid;
   logic                                rsp_stall;
   tasc_pkg::rsp_type                   rsp_data;
   logic                                csr_valid;
   logic                                csr_ready;
   logic [tasc_pkg::CSR_IDX_WIDTH-1:0]  csr_index;
   logic [tasc_pkg::CSR_DATA_WIDTH-1:0] csr_data;

   // servo state as seen by the predictor
   logic signed [tasc_pkg::POS_WIDTH-1:0] az_cnt, el_cnt;
   logic [tasc_pkg::WORD_WIDTH-1:0]       az_goal, el_goal;
   logic [1:0]                            act;
   logic                                  az_dir, el_dir;
   logic [tasc_pkg::DUTY_WIDTH-1:0]       az_duty, el_duty;
   logic [tasc_pkg::BAND_WIDTH-1:0]       far_band, near_band;
   logic [tasc_pkg::DUTY_WIDTH-1:0]       full_power, mid_power, low_power;

   tasc_pkg::rsp_type expected_rsp[$];
   stim_row_type      plan[$];
   int                err_count = 0;
   int                rsp_count = 0;
   int                send_gap_pct = 0;
   int                stall_pct = 0;
   bit                row_typed;
   tasc_pkg::rsp_type row_rsp;

   two_axis_encoder_seek_controller i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #10;
      clock = 1'b1;
      #10;
      clock = 1'b0;
   end

   function automatic logic signed [tasc_pkg::POS_WIDTH-1:0] aim_of(
      input logic [tasc_pkg::WORD_WIDTH-1:0] w
   );
      int mag;
      mag = int'(w[tasc_pkg::WORD_WIDTH-2:0]);
      return tasc_pkg::POS_WIDTH'(w[tasc_pkg::WORD_WIDTH-1] ? -mag : mag);
   endfunction

   function automatic tasc_pkg::rsp_type advance_servo(input tasc_pkg::req_type r);
      logic signed [tasc_pkg::POS_WIDTH-1:0] az_aim, el_aim;
      logic [tasc_pkg::DUTY_WIDTH-1:0]       tier;
      logic                                  done;
      tasc_pkg::rsp_type                     o;
      done = 1'b0;
      if (r.az_edge) begin
         az_cnt = r.az_level ? az_cnt + 1 : az_cnt - 1;
      end
      if (r.el_edge) begin
         el_cnt = r.el_level ? el_cnt + 1 : el_cnt - 1;
      end
      if (act == tasc_pkg::ACT_IDLE) begin
         case (r.mode)
            tasc_pkg::MODE_LOAD_AZ: az_goal = r.target_word;
            tasc_pkg::MODE_LOAD_EL: el_goal = r.target_word;
            tasc_pkg::MODE_ORIGIN: begin
               az_cnt = aim_of(az_goal);
               el_cnt = aim_of(el_goal);
            end
            tasc_pkg::MODE_SEEK: act = tasc_pkg::ACT_SEEK;
            tasc_pkg::MODE_HOME: act = tasc_pkg::ACT_HOME_AZ;
            tasc_pkg::MODE_DRIVE_AZ: begin
               az_dir  = r.drive_dir;
               az_duty = r.drive_power;
            end
            tasc_pkg::MODE_DRIVE_EL: begin
               el_dir  = r.drive_dir;
               el_duty = r.drive_power;
            end
            default: ;
         endcase
      end
      if (act == tasc_pkg::ACT_SEEK) begin
         az_aim = aim_of(az_goal);
         el_aim = aim_of(el_goal);
         if (el_goal[tasc_pkg::WORD_WIDTH-2:0] <= near_band) tier = low_power;
         else if (el_goal[tasc_pkg::WORD_WIDTH-2:0] <= far_band) tier = mid_power;
         else tier = full_power;
         if (az_cnt > az_aim) begin
            az_dir  = 1'b0;
            az_duty = full_power;
         end else if (az_cnt < az_aim) begin
            az_dir  = 1'b1;
            az_duty = full_power;
         end else begin
            az_dir  = 1'b0;
            az_duty = '0;
         end
         if (el_cnt > el_aim) begin
            el_dir  = 1'b0;
            el_duty = tier;
         end else if (el_cnt < el_aim) begin
            el_dir  = 1'b1;
            el_duty = tier;
         end else begin
            el_dir  = 1'b0;
            el_duty = '0;
         end
         if (az_cnt == az_aim && el_cnt == el_aim) begin
            act  = tasc_pkg::ACT_IDLE;
            done = 1'b1;
         end
      end else if (act != tasc_pkg::ACT_IDLE) begin
         if (act == tasc_pkg::ACT_HOME_AZ) begin
            az_dir = 1'b0;
            if (r.az_index) begin
               az_duty = '0;
               az_cnt  = '0;
               act     = tasc_pkg::ACT_HOME_EL;
            end else begin
               az_duty = full_power;
            end
         end
         // elevation homing may start on the tick azimuth finds its index
         if (act == tasc_pkg::ACT_HOME_EL) begin
            if (r.el_index) begin
               el_dir  = 1'b0;
               el_duty = '0;
               el_cnt  = '0;
               act     = tasc_pkg::ACT_IDLE;
               done    = 1'b1;
            end else begin
               el_dir  = 1'b1;
               el_duty = full_power;
            end
         end
      end
      o.az_position  = az_cnt;
      o.el_position  = el_cnt;
      o.az_direction = az_dir;
      o.az_duty      = az_duty;
      o.el_direction = el_dir;
      o.el_duty      = el_duty;
      o.activity     = act;
      o.finished     = done;
      return o;
   endfunction

   function automatic logic [tasc_pkg::WORD_WIDTH-1:0] random_target();
      int pick;
      pick = $urandom_range(9);
      if (pick < 7) begin
         return {1'($urandom_range(1)), 15'($urandom_range(150))};
      end else if (pick == 7) begin
         case ($urandom_range(3))
            0: return 16'h0000;
            1: return 16'h7FFF;
            2: return 16'h8000;
            default: return 16'hFFFF;
         endcase
      end
      return tasc_pkg::WORD_WIDTH'($urandom);
   endfunction

   // steers encoder samples towards the targets while seeking
   function automatic tasc_pkg::req_type random_item();
      tasc_pkg::req_type                     r;
      int                                    pick, gap_az, gap_el;
      logic signed [tasc_pkg::POS_WIDTH-1:0] az_aim, el_aim;
      az_aim        = aim_of(az_goal);
      el_aim        = aim_of(el_goal);
      r.mode        = tasc_pkg::MODE_TICK;
      r.target_word = random_target();
      r.drive_dir   = 1'($urandom_range(1));
      r.drive_power = tasc_pkg::DUTY_WIDTH'($urandom_range(255));
      r.az_edge     = 1'($urandom_range(1));
      r.az_level    = 1'($urandom_range(1));
      r.el_edge     = 1'($urandom_range(1));
      r.el_level    = 1'($urandom_range(1));
      r.az_index    = 1'($urandom_range(1));
      r.el_index    = 1'($urandom_range(1));
      case (act)
         tasc_pkg::ACT_SEEK: begin
            if ($urandom_range(9) == 0) begin
               r.mode = 3'($urandom_range(tasc_pkg::MODE_DRIVE_EL, tasc_pkg::MODE_LOAD_AZ));
            end
            r.az_edge = (az_cnt != az_aim) ? ($urandom_range(9) < 7) : ($urandom_range(9) < 2);
            r.el_edge = (el_cnt != el_aim) ? ($urandom_range(9) < 7) : ($urandom_range(9) < 2);
            if ($urandom_range(9) < 8) r.az_level = (az_cnt < az_aim);
            if ($urandom_range(9) < 8) r.el_level = (el_cnt < el_aim);
         end
         tasc_pkg::ACT_HOME_AZ, tasc_pkg::ACT_HOME_EL: begin
            if ($urandom_range(9) == 0) begin
               r.mode = 3'($urandom_range(tasc_pkg::MODE_DRIVE_EL, tasc_pkg::MODE_LOAD_AZ));
            end
            r.az_index = ($urandom_range(5) == 0);
            r.el_index = ($urandom_range(5) == 0);
         end
         default: begin
            pick = $urandom_range(99);
            if (pick < 25) r.mode = tasc_pkg::MODE_TICK;
            else if (pick < 40) r.mode = tasc_pkg::MODE_LOAD_AZ;
            else if (pick < 55) r.mode = tasc_pkg::MODE_LOAD_EL;
            else if (pick < 63) r.mode = tasc_pkg::MODE_ORIGIN;
            else if (pick < 75) r.mode = tasc_pkg::MODE_SEEK;
            else if (pick < 83) r.mode = tasc_pkg::MODE_HOME;
            else if (pick < 91) r.mode = tasc_pkg::MODE_DRIVE_AZ;
            else r.mode = tasc_pkg::MODE_DRIVE_EL;
            if (r.mode == tasc_pkg::MODE_SEEK) begin
               gap_az = int'(az_cnt) - int'(az_aim);
               gap_el = int'(el_cnt) - int'(el_aim);
               if (gap_az < 0) gap_az = -gap_az;
               if (gap_el < 0) gap_el = -gap_el;
               // too far to reach in reasonable time: jump there instead
               if (gap_az > SEEK_REACH || gap_el > SEEK_REACH) r.mode = tasc_pkg::MODE_ORIGIN;
            end
         end
      endcase
      return r;
   endfunction

   // pins: az_edge, az_level, el_edge, el_level, az_index, el_index
   function automatic tasc_pkg::req_type cmd(input logic [2:0] mode,
                                             input logic [tasc_pkg::WORD_WIDTH-1:0] word,
                                             input logic dir,
                                             input logic [tasc_pkg::DUTY_WIDTH-1:0] pwr,
                                             input logic [5:0] pins);
      tasc_pkg::req_type r;
      r.mode        = mode;
      r.target_word = word;
      r.drive_dir   = dir;
      r.drive_power = pwr;
      {r.az_edge, r.az_level, r.el_edge, r.el_level, r.az_index, r.el_index} = pins;
      return r;
   endfunction

   function automatic tasc_pkg::rsp_type res(input logic [tasc_pkg::POS_WIDTH-1:0] az, el,
                                             input logic azd,
                                             input logic [tasc_pkg::DUTY_WIDTH-1:0] azp,
                                             input logic eld,
                                             input logic [tasc_pkg::DUTY_WIDTH-1:0] elp,
                                             input logic [1:0] a,
                                             input logic f);
      tasc_pkg::rsp_type o;
      o.az_position  = az;
      o.el_position  = el;
      o.az_direction = azd;
      o.az_duty      = azp;
      o.el_direction = eld;
      o.el_duty      = elp;
      o.activity     = a;
      o.finished     = f;
      return o;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      err_count++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("result %0d %s got %0h want %0h", rsp_count, name, got, want));
      end
   endtask

   task automatic send_request(input tasc_pkg::req_type r, input bit typed,
                               input tasc_pkg::rsp_type t);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      row_typed <= typed;
      row_rsp   <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [tasc_pkg::CSR_IDX_WIDTH-1:0] idx,
                            input logic [tasc_pkg::CSR_DATA_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         tasc_pkg::CSR_FAR_BAND:   far_band   = data[tasc_pkg::BAND_WIDTH-1:0];
         tasc_pkg::CSR_NEAR_BAND:  near_band  = data[tasc_pkg::BAND_WIDTH-1:0];
         tasc_pkg::CSR_FULL_POWER: full_power = data[tasc_pkg::DUTY_WIDTH-1:0];
         tasc_pkg::CSR_MID_POWER:  mid_power  = data[tasc_pkg::DUTY_WIDTH-1:0];
         tasc_pkg::CSR_LOW_POWER:  low_power  = data[tasc_pkg::DUTY_WIDTH-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic drain_results();
      int waited = 0;
      while (expected_rsp.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (expected_rsp.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", expected_rsp.size()));
         expected_rsp.delete();
      end
      repeat (DRAIN_TAIL) @(posedge clock);
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      tasc_pkg::rsp_type want, got;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = rsp_data;
            rsp_count++;
            if (expected_rsp.size() == 0) begin
               report_mismatch($sformatf("result %0d with no transaction outstanding", rsp_count));
            end else begin
               want = expected_rsp.pop_front();
               check_field("az_position", got.az_position, want.az_position);
               check_field("el_position", got.el_position, want.el_position);
               check_field("az_direction", got.az_direction, want.az_direction);
               check_field("az_duty", got.az_duty, want.az_duty);
               check_field("el_direction", got.el_direction, want.el_direction);
               check_field("el_duty", got.el_duty, want.el_duty);
               check_field("activity", got.activity, want.activity);
               check_field("finished", got.finished, want.finished);
            end
         end
         if (req_valid && !req_stall) begin
            want = advance_servo(req_data);
            expected_rsp.push_back(row_typed ? row_rsp : want);
         end
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb: failure");
      $finish;
   end

   initial begin
      tasc_pkg::req_type                   r;
      bit                                  ignored;
      int                                  n;
      logic [tasc_pkg::CSR_DATA_WIDTH-1:0] data;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      row_typed = 1'b0;
      row_rsp   = '0;
      az_cnt = '0;
      el_cnt = '0;
      az_goal = '0;
      el_goal = '0;
      act = tasc_pkg::ACT_IDLE;
      az_dir = 1'b0;
      el_dir = 1'b0;
      az_duty = '0;
      el_duty = '0;
      far_band   = tasc_pkg::FAR_BAND_RST;
      near_band  = tasc_pkg::NEAR_BAND_RST;
      full_power = tasc_pkg::FULL_POWER_RST;
      mid_power  = tasc_pkg::MID_POWER_RST;
      low_power  = tasc_pkg::LOW_POWER_RST;

      plan.push_back('{cmd(tasc_pkg::MODE_TICK, 16'h0000, 1'b0, 8'd0, 6'b000000), 1'b1,
                       res(16'h0000, 16'h0000, 1'b0, 8'd0, 1'b0, 8'd0, tasc_pkg::ACT_IDLE, 1'b0)});
      plan.push_back('{cmd(tasc_pkg::MODE_TICK, 16'h0000, 1'b0, 8'd0, 6'b110000), 1'b1,
                       res(16'h0001, 16'h0000, 1'b0, 8'd0, 1'b0, 8'd0, tasc_pkg::ACT_IDLE, 1'b0)});
      plan.push_back('{cmd(tasc_pkg::MODE_TICK, 16'h0000, 1'b0, 8'd0, 6'b001000), 1'b1,
                       res(16'h0001, 16'hFFFF, 1'b0, 8'd0, 1'b0, 8'd0, tasc_pkg::ACT_IDLE, 1'b0)});
      plan.push_back('{cmd(tasc_pkg::MODE_LOAD_AZ, 16'h7FFF, 1'b0, 8'd0, 6'b000000), 1'b1,
                       res(16'h0001, 16'hFFFF, 1'b0, 8'd0, 1'b0, 8'd0, tasc_pkg::ACT_IDLE, 1'b0)});
      // negative zero
      plan.push_back('{cmd(tasc_pkg::MODE_LOAD_EL, 16'h8000, 1'b0, 8'd0, 6'b000000), 1'b1,
                       res(16'h0001, 16'hFFFF, 1'b0, 8'd0, 1'b0, 8'd0, tasc_pkg::ACT_IDLE, 1'b0)});
      plan.push_back('{cmd(tasc_pkg::MODE_ORIGIN, 16'h0000, 1'b0, 8'd0, 6'b000000), 1'b1,
                       res(16'h7FFF, 16'h0000, 1'b0, 8'd0, 1'b0, 8'd0, tasc_pkg::ACT_IDLE, 1'b0)});
      plan.push_back('{cmd(tasc_pkg::MODE_TICK, 16'h0000, 1'b0, 8'd0, 6'b110000), 1'b1,
                       res(16'h8000, 16'h0000, 1'b0, 8'd0, 1'b0, 8'd0, tasc_pkg::ACT_IDLE, 1'b0)});
      plan.push_back('{cmd(tasc_pkg::MODE_DRIVE_AZ, 16'h0000, 1'b1, 8'd255, 6'b000000), 1'b1,
                       res(16'h8000, 16'h0000, 1'b1, 8'd255, 1'b0, 8'd0, tasc_pkg::ACT_IDLE,
                           1'b0)});
      plan.push_back('{cmd(tasc_pkg::MODE_DRIVE_EL, 16'h0000, 1'b1, 8'd1, 6'b000000), 1'b1,
                       res(16'h8000, 16'h0000, 1'b1, 8'd255, 1'b1, 8'd1, tasc_pkg::ACT_IDLE,
                           1'b0)});
      plan.push_back('{cmd(tasc_pkg::MODE_LOAD_AZ, 16'hFFFF, 1'b0, 8'd0, 6'b000000), 1'b0, '0});
      plan.push_back('{cmd(tasc_pkg::MODE_ORIGIN, 16'h0000, 1'b0, 8'd0, 6'b000000), 1'b0, '0});
      plan.push_back('{cmd(tasc_pkg::MODE_LOAD_EL, 16'h0002, 1'b0, 8'd0, 6'b000000), 1'b0, '0});
      plan.push_back('{cmd(tasc_pkg::MODE_SEEK, 16'h0000, 1'b0, 8'd0, 6'b100000), 1'b0, '0});
      plan.push_back('{cmd(tasc_pkg::MODE_HOME, 16'h0000, 1'b0, 8'd0, 6'b110000), 1'b0, '0});
      plan.push_back('{cmd(tasc_pkg::MODE_TICK, 16'h0000, 1'b0, 8'd0, 6'b001100), 1'b0, '0});
      plan.push_back('{cmd(tasc_pkg::MODE_DRIVE_AZ, 16'h0000, 1'b1, 8'd9, 6'b001100), 1'b0, '0});
      plan.push_back('{cmd(tasc_pkg::MODE_HOME, 16'h0000, 1'b0, 8'd0, 6'b000000), 1'b0, '0});
      // both index switches on the same tick
      plan.push_back('{cmd(tasc_pkg::MODE_TICK, 16'h0000, 1'b0, 8'd0, 6'b000011), 1'b0, '0});
      plan.push_back('{cmd(tasc_pkg::MODE_HOME, 16'h0000, 1'b0, 8'd0, 6'b000010), 1'b0, '0});
      plan.push_back('{cmd(tasc_pkg::MODE_LOAD_EL, 16'h1234, 1'b0, 8'd0, 6'b000000), 1'b0, '0});
      plan.push_back('{cmd(tasc_pkg::MODE_TICK, 16'h0000, 1'b0, 8'd0, 6'b000001), 1'b0, '0});
      plan.push_back('{cmd(tasc_pkg::MODE_LOAD_EL, 16'h8000, 1'b0, 8'd0, 6'b000000), 1'b0, '0});
      plan.push_back('{cmd(tasc_pkg::MODE_LOAD_AZ, 16'h0000, 1'b0, 8'd0, 6'b000000), 1'b0, '0});
      // already on target: done on the same tick
      plan.push_back('{cmd(tasc_pkg::MODE_SEEK, 16'h0000, 1'b0, 8'd0, 6'b000000), 1'b0, '0});
      plan.push_back('{cmd(tasc_pkg::MODE_TICK, 16'hFFFF, 1'b1, 8'd255, 6'b111111), 1'b0, '0});

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      for (int p = 0; p < PHASE_COUNT; p++) begin
         if (p != 0) begin
            req_valid <= 1'b0;
            drain_results();
            for (int k = tasc_pkg::CSR_FAR_BAND; k <= tasc_pkg::CSR_LOW_POWER; k++) begin
               if (p == 1) data = '1;
               else if (p == 2) data = '0;
               else if (k <= tasc_pkg::CSR_NEAR_BAND) begin
                  data = tasc_pkg::CSR_DATA_WIDTH'($urandom_range(120));
               end else data = tasc_pkg::CSR_DATA_WIDTH'($urandom);
               write_reg(tasc_pkg::CSR_IDX_WIDTH'(k), data);
            end
            write_reg(tasc_pkg::CSR_IDX_WIDTH'($urandom_range(CSR_INDEX_TOP,
                                                             tasc_pkg::CSR_LOW_POWER + 1)),
                      tasc_pkg::CSR_DATA_WIDTH'($urandom));
            csr_valid <= 1'b0;
         end
         case (idle_mode_type'(p % 4))
            IDLE_SENDER: begin
               send_gap_pct = 82;
               stall_pct    = 0;
            end
            IDLE_RECEIVER: begin
               send_gap_pct = 0;
               stall_pct    = 82;
            end
            IDLE_BOTH: begin
               send_gap_pct = 27;
               stall_pct    = 27;
            end
            default: begin
               send_gap_pct = 0;
               stall_pct    = 0;
            end
         endcase
         if (p == 0) begin
            foreach (plan[i]) send_request(plan[i].req, plan[i].typed, plan[i].rsp);
         end
         n = 0;
         while (n < PHASE_ITEMS) begin
            r = random_item();
            ignored = (act != tasc_pkg::ACT_IDLE && r.mode != tasc_pkg::MODE_TICK);
            send_request(r, 1'b0, '0);
            if (!ignored) n++;
         end
      end
      req_valid <= 1'b0;
      drain_results();

      if (err_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
